FILE: rtl/fdk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdk_pkg: shared types and codes for the keyed queue
// Command and status codes, and the control bundle that drives the cells.
// ----------------------------------------------------------------------------
package fdk_pkg;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_REMOVE  = 2'd1,
        CMD_DEQUEUE = 2'd2
    } cmd_t;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_EMPTY     = 2'd2;
    localparam logic [1:0] STAT_FULL      = 2'd3;

    // Per-cell control: shift takes the right neighbor's key, load takes the
    // broadcast key. Load wins over shift.
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

endpackage

FILE: rtl/fdk_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdk_cell: one storage cell of the key chain
// Holds one key and either keeps it, takes its right neighbor's key or loads
// the broadcast key.
// ----------------------------------------------------------------------------
module fdk_cell #(
    parameter int KEY_BITS = 32
) (
    input  logic                  aclk,
    input  fdk_pkg::cell_ctl_t    ctl,
    input  logic [KEY_BITS-1:0]   right_key,
    input  logic [KEY_BITS-1:0]   load_key,
    output logic [KEY_BITS-1:0]   key
);

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;

    always_comb begin
        key_next = key_reg;
        if (ctl.load) begin
            key_next = load_key;
        end else if (ctl.shift) begin
            key_next = right_key;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

    assign key = key_reg;

endmodule

FILE: rtl/fdk_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdk_ctrl: command sequencer and result register for the keyed queue
// Decodes commands, keeps the fill count, runs the rotation scan for removes
// and holds the result until it is taken.
// ----------------------------------------------------------------------------
module fdk_ctrl #(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 32,
    parameter int CW       = $clog2(DEPTH + 1),
    parameter int IW       = $clog2(DEPTH)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_cmd,
    input  logic [KEY_BITS-1:0]   s_key,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [KEY_BITS-1:0]   m_out_key,
    output logic [1:0]            m_status,
    output logic [CW-1:0]         m_occupancy,
    input  logic [KEY_BITS-1:0]   head_key,
    output fdk_pkg::cell_ctl_t    ctl,
    output logic [IW-1:0]         load_idx,
    output logic [KEY_BITS-1:0]   load_key
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic [CW-1:0]       rem_reg, rem_next;
    logic                found_reg, found_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic                m_valid_reg, m_valid_next;
    logic [KEY_BITS-1:0] out_key_reg, out_key_next;
    logic [1:0]          status_reg, status_next;
    logic [CW-1:0]       occ_reg, occ_next;

    logic                accept;
    logic                out_load;
    logic                drop;
    logic [CW-1:0]       fill_m1;

    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign fill_m1 = fill_reg - 1'b1;
    assign drop    = !found_reg && (head_key == key_reg);

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        rem_next     = rem_reg;
        found_next   = found_reg;
        key_next     = key_reg;
        out_load     = 1'b0;
        out_key_next = '0;
        status_next  = fdk_pkg::STAT_OK;
        ctl          = '0;
        load_idx     = '0;
        load_key     = s_key;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (fdk_pkg::cmd_t'(s_cmd))
                        fdk_pkg::CMD_ENQUEUE: begin
                            out_load = 1'b1;
                            if (fill_reg == CW'(DEPTH)) begin
                                status_next = fdk_pkg::STAT_FULL;
                            end else begin
                                ctl.load  = 1'b1;
                                load_idx  = fill_reg[IW-1:0];
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        fdk_pkg::CMD_REMOVE: begin
                            if (fill_reg == '0) begin
                                out_load    = 1'b1;
                                status_next = fdk_pkg::STAT_NOT_FOUND;
                            end else begin
                                key_next   = s_key;
                                found_next = 1'b0;
                                rem_next   = fill_reg;
                                state_next = S_SCAN;
                            end
                        end
                        fdk_pkg::CMD_DEQUEUE: begin
                            out_load = 1'b1;
                            if (fill_reg == '0) begin
                                status_next = fdk_pkg::STAT_EMPTY;
                            end else begin
                                out_key_next = head_key;
                                ctl.shift    = 1'b1;
                                fill_next    = fill_m1;
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // The head leaves cell 0 each cycle; every key but the first
                // match is written back behind the live entries.
                ctl.shift = 1'b1;
                load_key  = head_key;
                if (drop) begin
                    found_next = 1'b1;
                    fill_next  = fill_m1;
                end else begin
                    ctl.load = 1'b1;
                    load_idx = fill_m1[IW-1:0];
                end
                rem_next = rem_reg - 1'b1;
                if (rem_reg == CW'(1)) begin
                    out_load    = 1'b1;
                    status_next = (found_reg || drop) ? fdk_pkg::STAT_OK
                                                      : fdk_pkg::STAT_NOT_FOUND;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        occ_next = fill_next;

        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
            found_reg   <= 1'b0;
            rem_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
            found_reg   <= found_next;
            rem_reg     <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        if (out_load) begin
            out_key_reg <= out_key_next;
            status_reg  <= status_next;
            occ_reg     <= occ_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_key   = out_key_reg;
    assign m_status    = status_reg;
    assign m_occupancy = occ_reg;

endmodule

FILE: rtl/fifo_with_delete_by_key.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_with_delete_by_key: ordered key queue with remove-by-key
// A chain of key cells, oldest at cell 0, driven by a small sequencer that
// appends, pops the head, or deletes the oldest matching key.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                     Direction
//   -------   ---------------------------------------   ---------
//   request   s_valid s_ready s_cmd s_key               in
//   result    m_valid m_ready m_out_key m_status        out
//             m_occupancy
//
// Enqueue, dequeue, the unused code and a remove on an empty queue finish in
// the cycle the request is taken, with the result registered at the end of that cycle.
// A remove on a queue holding N keys rotates all N keys through cell 0, where
// one comparator looks at each in turn, and all but the first match are
// written back at the tail, so the order of the rest is kept.
// A request is taken only while no remove is scanning and the result register
// is empty or being emptied in the same cycle. A stalled result holds the
// sequencer. Reset clears the fill count and the handshake state; the cells
// hold no reset and are only read below the fill count.
//
module fifo_with_delete_by_key #(
    parameter int DEPTH    = 16,
    parameter int KEY_BITS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_cmd,
    input  logic [KEY_BITS-1:0]          s_key,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [KEY_BITS-1:0]          m_out_key,
    output logic [1:0]                   m_status,
    output logic [$clog2(DEPTH+1)-1:0]   m_occupancy
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    fdk_pkg::cell_ctl_t  ctl;
    logic [IW-1:0]       load_idx;
    logic [KEY_BITS-1:0] load_key;
    logic [KEY_BITS-1:0] cell_key [DEPTH];

    fdk_ctrl #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS),
        .CW       (CW),
        .IW       (IW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_key       (s_key),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_key   (m_out_key),
        .m_status    (m_status),
        .m_occupancy (m_occupancy),
        .head_key    (cell_key[0]),
        .ctl         (ctl),
        .load_idx    (load_idx),
        .load_key    (load_key)
    );

    // Every cell shifts together; only the addressed cell loads. The last
    // cell feeds back its own key, since nothing lies to its right.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        fdk_pkg::cell_ctl_t  c;
        logic [KEY_BITS-1:0] right;

        assign c.shift = ctl.shift;
        assign c.load  = ctl.load && (load_idx == IW'(i));

        if (i == DEPTH - 1) begin : g_last
            assign right = cell_key[i];
        end else begin : g_mid
            assign right = cell_key[i+1];
        end

        fdk_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (c),
            .right_key (right),
            .load_key  (load_key),
            .key       (cell_key[i])
        );
    end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the keyed queue with remove-by-key
// Drives enqueue, remove and dequeue requests through the valid/ready input
// channel. It keeps a shadow copy of the queue that predicts every result, and
// checks each result field by field. The run is a short table of directed
// requests followed by random fill and drain phases, with random idling on
// both channels.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DEPTH           = 16;
    localparam int KEY_BITS        = 32;
    localparam int OCC_BITS        = $clog2(DEPTH + 1);
    localparam int RANDOM_REQUESTS = 1700;
    localparam int DRAIN_CYCLES    = 40;
    // Slowest legal run is roughly 1725 requests times a full remove scan
    // plus the longest gaps on both sides; this is several times that.
    localparam longint TIMEOUT_NS  = 64'd10_000_000;

    // The package names only the three real commands; code 3 is a no-op.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [KEY_BITS-1:0] out_key;
        logic [1:0]          status;
        logic [OCC_BITS-1:0] occupancy;
    } queue_reply_t;

    typedef struct {
        logic [1:0]          cmd;
        logic [KEY_BITS-1:0] key;
        bit                  typed;
        queue_reply_t        reply;
    } stim_row_t;

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic [1:0]          s_cmd       = '0;
    logic [KEY_BITS-1:0] s_key       = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic [KEY_BITS-1:0] m_out_key;
    logic [1:0]          m_status;
    logic [OCC_BITS-1:0] m_occupancy;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    fifo_with_delete_by_key #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_key       (s_key),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_key   (m_out_key),
        .m_status    (m_status),
        .m_occupancy (m_occupancy)
    );

    // ------------------------------------------------------------------------
    // Shadow queue. It holds the keys oldest first, exactly as the block
    // should, and is advanced once for every request the block accepts.
    // ------------------------------------------------------------------------
    logic [KEY_BITS-1:0] shadow_keys[$];
    queue_reply_t        pending_replies[$];
    stim_row_t           stim_rows[$];
    int                  error_count = 0;
    // While calm is set, neither side idles, so back-to-back traffic is seen.
    bit                  calm = 1'b0;

    function automatic queue_reply_t apply_to_shadow(input logic [1:0] cmd,
                                                     input logic [KEY_BITS-1:0] key);
        queue_reply_t r;
        int           hit;
        r   = '0;
        hit = -1;
        case (cmd)
            fdk_pkg::CMD_ENQUEUE: begin
                if (shadow_keys.size() >= DEPTH)
                    r.status = fdk_pkg::STAT_FULL;
                else
                    shadow_keys.insert(shadow_keys.size(), key);
            end
            fdk_pkg::CMD_REMOVE: begin
                // Only the oldest matching key goes; the rest keep their order.
                for (int i = 0; i < shadow_keys.size() && hit < 0; i++)
                    if (shadow_keys[i] == key)
                        hit = i;
                if (hit < 0) begin
                    r.status = fdk_pkg::STAT_NOT_FOUND;
                end else begin
                    shadow_keys.delete(hit);
                    r.status = fdk_pkg::STAT_OK;
                end
            end
            fdk_pkg::CMD_DEQUEUE: begin
                if (shadow_keys.size() == 0) begin
                    r.status = fdk_pkg::STAT_EMPTY;
                end else begin
                    r.out_key = shadow_keys[0];
                    shadow_keys.delete(0);
                end
            end
            default: ; // The unused code leaves the queue alone and reports OK.
        endcase
        r.occupancy = OCC_BITS'(shadow_keys.size());
        return r;
    endfunction

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (calm || p < 55)
            return 0;
        if (p < 88)
            return $urandom_range(1, 3);
        if (p < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Small keys repeat often, so removes find duplicates; full-width keys
    // make every key bit take both values.
    function automatic logic [KEY_BITS-1:0] pick_key();
        if ($urandom_range(0, 9) < 6)
            return KEY_BITS'($urandom_range(0, 7));
        return $urandom;
    endfunction

    task automatic add_row(input logic [1:0] cmd, input logic [KEY_BITS-1:0] key,
                           input bit typed, input queue_reply_t reply);
        stim_row_t row;
        row.cmd   = cmd;
        row.key   = key;
        row.typed = typed;
        row.reply = reply;
        stim_rows.insert(stim_rows.size(), row);
    endtask

    // Presents one request and holds it until the block takes it. The result
    // it should cause is queued at the edge of acceptance; the block registers
    // its result at that edge or later, so the checker never races this.
    task automatic send_request(input logic [1:0] cmd, input logic [KEY_BITS-1:0] key,
                                input bit typed, input queue_reply_t given);
        queue_reply_t predicted;
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_key   <= key;
        do
            @(posedge aclk);
        while (!s_ready);
        predicted = apply_to_shadow(cmd, key);
        pending_replies.insert(pending_replies.size(), typed ? given : predicted);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure, with calm stretches of none.
    // ------------------------------------------------------------------------
    int unsigned stall_left = 0;

    always @(posedge aclk) begin
        if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0)
            stall_left = idle_len() + 1;
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Each accepted result is matched against the oldest waiting prediction.
    always @(posedge aclk) begin : check_replies
        queue_reply_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                $error("result with no request waiting: key %h status %0d occ %0d",
                       m_out_key, m_status, m_occupancy);
                error_count++;
            end else begin
                want = pending_replies[0];
                pending_replies.delete(0);
                if (m_out_key !== want.out_key) begin
                    $error("out_key: expected %h, got %h", want.out_key, m_out_key);
                    error_count++;
                end
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    error_count++;
                end
                if (m_occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d",
                           want.occupancy, m_occupancy);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side: the directed table first, then random fill and drain
    // phases that push the queue toward full and back toward empty again and again.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [1:0]          cmd;
        logic [KEY_BITS-1:0] key;
        int unsigned         pick;
        int unsigned         gap;
        int                  phase_left;
        bit                  filling;
        bit                  pause;

        // Rows whose result can be read straight off the spec carry it;
        // the rest are left to the shadow queue.
        add_row(fdk_pkg::CMD_DEQUEUE, '0, 1'b1,
                '{'0, fdk_pkg::STAT_EMPTY, OCC_BITS'(0)});         // pop on empty
        add_row(fdk_pkg::CMD_REMOVE, '0, 1'b1,
                '{'0, fdk_pkg::STAT_NOT_FOUND, OCC_BITS'(0)});     // remove on empty
        add_row(CMD_UNUSED, '1, 1'b1,
                '{'0, fdk_pkg::STAT_OK, OCC_BITS'(0)});            // unused code
        add_row(fdk_pkg::CMD_ENQUEUE, '0, 1'b1,
                '{'0, fdk_pkg::STAT_OK, OCC_BITS'(1)});
        add_row(fdk_pkg::CMD_ENQUEUE, '1, 1'b1,
                '{'0, fdk_pkg::STAT_OK, OCC_BITS'(2)});
        add_row(fdk_pkg::CMD_DEQUEUE, '1, 1'b1,
                '{'0, fdk_pkg::STAT_OK, OCC_BITS'(1)});            // all-zero key out
        add_row(fdk_pkg::CMD_DEQUEUE, '0, 1'b1,
                '{'1, fdk_pkg::STAT_OK, OCC_BITS'(0)});            // all-ones key out
        // Fill to the brim; every fifth key is the same, so a later remove
        // has to pick the oldest of several copies.
        for (int i = 0; i < DEPTH; i++)
            add_row(fdk_pkg::CMD_ENQUEUE,
                    (i % 5 == 0) ? 32'h0000_0BAD : 32'h5A00_0000 | i,
                    1'b1, '{'0, fdk_pkg::STAT_OK, OCC_BITS'(i + 1)});
        add_row(fdk_pkg::CMD_ENQUEUE, 32'hDEAD_BEEF, 1'b1,
                '{'0, fdk_pkg::STAT_FULL, OCC_BITS'(DEPTH)});      // full
        add_row(fdk_pkg::CMD_REMOVE, 32'h0000_0BAD, 1'b0, '0);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_rows[i])
            send_request(stim_rows[i].cmd, stim_rows[i].key, stim_rows[i].typed,
                         stim_rows[i].reply);

        filling    = 1'b0;
        phase_left = 0;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (phase_left == 0) begin
                filling    = !filling;
                phase_left = $urandom_range(20, 60);
                calm       = ($urandom_range(0, 3) == 0);
            end
            phase_left--;

            // Fill phases lean on enqueue, drain phases on remove and pop.
            pick = $urandom_range(0, 99);
            if (pick < (filling ? 60 : 25))
                cmd = fdk_pkg::CMD_ENQUEUE;
            else if (pick < (filling ? 78 : 60))
                cmd = fdk_pkg::CMD_REMOVE;
            else if (pick < 95)
                cmd = fdk_pkg::CMD_DEQUEUE;
            else
                cmd = CMD_UNUSED;

            // Most removes name a key that is really held, anywhere in the queue.
            if (cmd == fdk_pkg::CMD_REMOVE && shadow_keys.size() != 0 &&
                $urandom_range(0, 9) < 7)
                key = shadow_keys[$urandom_range(0, shadow_keys.size() - 1)];
            else if (cmd == fdk_pkg::CMD_ENQUEUE || cmd == fdk_pkg::CMD_REMOVE)
                key = pick_key();
            else
                key = $urandom;

            send_request(cmd, key, 1'b0, '0);

            // Now and then let every outstanding result come home before the
            // next request, so the block is seen starting from idle.
            pause = (n % 400 == 399);
            gap   = idle_len();
            if (gap != 0 || pause) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
                while (pause && pending_replies.size() != 0)
                    @(posedge aclk);
            end
        end
        s_valid <= 1'b0;
        calm    <= 1'b0;

        while (pending_replies.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && pending_replies.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // A hung handshake must not keep the run alive forever.
    initial begin
        #(TIMEOUT_NS);
        $display("testbench NOT OK");
        $finish;
    end

endmodule
